### hw/rtl/pat_pkg.sv
// Package for the pending acknowledgement tracker: table size, command and
// error codes, item, result, scan-carry and write-port types.
// No dependencies.
`default_nettype none

package pat_pkg;

  localparam int SLOTS  = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = 4;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_RESULT = 2'd1;
  localparam logic [1:0] CMD_DROP   = 2'd2;

  localparam logic [7:0] ERR_ACK        = 8'd0;
  localparam logic [7:0] ERR_NO_CHANNEL = 8'd6;

  localparam logic [CNT_W-1:0] DROP_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] node_id;
    logic [31:0] packet_id;
    logic [7:0]  error_reason;
    logic        used_pki;
    logic [31:0] time_ms;
  } item_t;

  typedef struct packed {
    logic       matched;
    logic       acked;
    logic       hint_valid;
    logic       no_pki_hint;
    logic [2:0] slot_used;
    logic       evicted;
    logic [3:0] dropped_count;
  } result_t;

  // Search state handed from cell to cell during a sweep.
  typedef struct packed {
    logic              valid;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] oldest_idx;
    logic [31:0]       oldest_time;
    logic              ex_found;
    logic [SLOT_W-1:0] ex_idx;
    logic              ex_pki;
    logic              pk_found;
    logic [SLOT_W-1:0] pk_idx;
    logic              pk_pki;
    logic [CNT_W-1:0]  drop_cnt;
  } carry_t;

  // Commit write broadcast to all cells after the sweep.
  typedef struct packed {
    logic              set;
    logic              clr;
    logic [SLOT_W-1:0] idx;
  } wr_t;

endpackage

`default_nettype wire

### hw/rtl/pat_cell.sv
// One table slot of the pending acknowledgement tracker plus its stage of
// the search sweep. Depends on pat_pkg.
`default_nettype none

module pat_cell
  import pat_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [SLOT_W-1:0] my_idx,
  input  wire item_t             item,
  input  wire wr_t               wr,
  input  wire carry_t            cin,
  output carry_t                 cout
);

  logic        active;
  logic [31:0] packet;
  logic [31:0] node;
  logic [31:0] sent_time;
  logic        pki;

  logic   pkt_hit;
  logic   node_hit;
  logic   drop_hit;
  logic   wr_hit;
  carry_t cout_next;

  assign pkt_hit  = active && (packet == item.packet_id);
  assign node_hit = active && (node == item.node_id);
  assign drop_hit = cin.valid && (item.command == CMD_DROP) && node_hit;
  assign wr_hit   = (wr.idx == my_idx);

  always_comb begin
    cout_next = cin;
    if (!cin.free_found) begin
      if (!active) begin
        cout_next.free_found = 1'b1;
        cout_next.free_idx   = my_idx;
      end else if (sent_time < cin.oldest_time) begin
        cout_next.oldest_idx  = my_idx;
        cout_next.oldest_time = sent_time;
      end
    end
    if (!cin.ex_found && pkt_hit && node_hit) begin
      cout_next.ex_found = 1'b1;
      cout_next.ex_idx   = my_idx;
      cout_next.ex_pki   = pki;
    end
    if (!cin.pk_found && pkt_hit) begin
      cout_next.pk_found = 1'b1;
      cout_next.pk_idx   = my_idx;
      cout_next.pk_pki   = pki;
    end
    if (drop_hit && (cin.drop_cnt != DROP_MAX)) begin
      cout_next.drop_cnt = cin.drop_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cout   <= '0;
    end else begin
      cout <= cout_next;
      if (wr.set && wr_hit) begin
        active <= 1'b1;
      end else if ((wr.clr && wr_hit) || drop_hit) begin
        active <= 1'b0;
      end
    end
    if (wr.set && wr_hit) begin
      packet    <= item.packet_id;
      node      <= item.node_id;
      sent_time <= item.time_ms;
      pki       <= item.used_pki;
    end
  end

  // A drop never coincides with a commit write: the commit follows the sweep.
  assert property (@(posedge clk) disable iff (rst) !(drop_hit && (wr.set || wr.clr)))
    else $error("drop clear overlaps commit write");
  assert property (@(posedge clk) disable iff (rst)
    (wr.set && wr_hit) |=> active)
    else $error("record write did not activate slot");
  assert property (@(posedge clk) disable iff (rst)
    drop_hit |=> !active)
    else $error("dropped slot still active");

endmodule

`default_nettype wire

### hw/rtl/pending_ack_tracker.sv
// Pending acknowledgement tracker: a row of SLOTS cells swept one cell a cycle.
// An accepted item passes the launch register, then each cell's carry register in turn, then done.
// A new item is taken only after the previous one has left the sweep and committed; busy holds start off.
// busy is low again in the cycle that carries done; the receiver cannot stall.
// Reset (rst, synchronous) frees every slot and idles the sweep; no clearing pass.
`default_nettype none

module pending_ack_tracker
  import pat_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  output logic       busy,
  input  wire item_t item,
  output logic       done,
  output result_t    result
);

  item_t   cmd_q;
  logic    launch;
  carry_t  chain [SLOTS+1];
  carry_t  fin;
  wr_t     wr;
  result_t res_next;
  logic [SLOTS:0] vbits;
  logic           accept;

  logic [SLOT_W-1:0] hit_idx;
  logic              hit_pki;
  logic              hit;

  assign accept = start && !busy;

  always_comb begin
    chain[0]             = '0;
    chain[0].valid       = launch;
    chain[0].oldest_time = '1;
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    pat_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .my_idx (SLOT_W'(i)),
      .item   (cmd_q),
      .wr     (wr),
      .cin    (chain[i]),
      .cout   (chain[i+1])
    );
  end

  for (genvar i = 0; i <= SLOTS; i++) begin : g_vbits
    assign vbits[i] = chain[i].valid;
  end

  assign fin = chain[SLOTS];

  always_comb begin
    hit     = 1'b0;
    hit_idx = fin.pk_idx;
    hit_pki = fin.pk_pki;
    if (fin.ex_found) begin
      hit     = 1'b1;
      hit_idx = fin.ex_idx;
      hit_pki = fin.ex_pki;
    end else if (fin.pk_found) begin
      hit = 1'b1;
    end
  end

  always_comb begin
    res_next = '0;
    wr       = '0;
    wr.idx   = fin.free_found ? fin.free_idx : fin.oldest_idx;
    unique case (cmd_q.command)
      CMD_RECORD: begin
        wr.set             = fin.valid;
        res_next.slot_used = 3'(wr.idx);
        res_next.evicted   = !fin.free_found;
      end
      CMD_RESULT: begin
        if (hit) begin
          wr.idx             = hit_idx;
          wr.clr             = fin.valid;
          res_next.matched   = 1'b1;
          res_next.slot_used = 3'(hit_idx);
          if (cmd_q.error_reason == ERR_ACK) begin
            res_next.acked       = 1'b1;
            res_next.hint_valid  = 1'b1;
            res_next.no_pki_hint = !hit_pki;
          end else if (cmd_q.error_reason == ERR_NO_CHANNEL) begin
            res_next.hint_valid  = 1'b1;
            res_next.no_pki_hint = hit_pki;
          end
        end
      end
      CMD_DROP: begin
        res_next.dropped_count = 4'(fin.drop_cnt);
      end
      default: begin
        // unused command code: no change, zero result
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      launch <= 1'b0;
      done   <= 1'b0;
    end else begin
      launch <= accept;
      done   <= fin.valid;
      if (accept) begin
        busy <= 1'b1;
      end else if (fin.valid) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= item;
    end
    if (fin.valid) begin
      result <= res_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) $onehot0(vbits))
    else $error("more than one item in the sweep");
  assert property (@(posedge clk) disable iff (rst) (vbits != '0) |-> busy)
    else $error("sweep running while not busy");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("busy still set at done strobe");
  assert property (@(posedge clk) disable iff (rst)
    (done && result.matched) |-> (cmd_q.command == CMD_RESULT))
    else $error("match reported for a non-result command");
  assert property (@(posedge clk) disable iff (rst)
    (done && result.evicted) |-> (cmd_q.command == CMD_RECORD))
    else $error("eviction reported for a non-record command");

endmodule

`default_nettype wire

### test/testbench.sv
// Testbench for pending_ack_tracker: directed and random record, result and drop items
// checked against a table predictor kept in step with every accepted item.
// Depends on pat_pkg (hw/rtl/pat_pkg.sv) and the pending_ack_tracker RTL.
`timescale 1ns / 100ps

module testbench;
  import pat_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RAND_ITEMS = 1600;
  localparam int BATCH = 400;

  typedef struct packed {
    logic        active;
    logic [31:0] pkt;
    logic [31:0] node;
    logic [31:0] sent;
    logic        pki;
  } ack_slot_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item_d = '0;
  logic    busy;
  logic    done;
  result_t result;

  item_t       stim_q[$];
  result_t     expect_q[$];
  ack_slot_t   ack_table[SLOTS];
  int          sent_cnt = 0;
  int          fail_cnt = 0;

  // generator state
  logic [31:0] node_pool[4];
  logic [31:0] recent_pkts[$];
  logic [31:0] clock_ms = 32'd0;

  pending_ack_tracker dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item_d),
    .done  (done),
    .result(result)
  );

  always #6 clk = ~clk;

  // Expected answer for one item; updates the shadow table.
  function automatic result_t track_step(item_t it);
    result_t r;
    int      hit;
    int      oldest;
    int      cnt;
    r = '0;
    hit = -1;
    oldest = 0;
    cnt = 0;
    case (it.command)
      CMD_RECORD: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!ack_table[i].active && hit < 0) hit = i;
        end
        if (hit < 0) begin
          // table full: oldest send time, lowest index on a tie, no wrap
          for (int i = 1; i < SLOTS; i++) begin
            if (ack_table[i].sent < ack_table[oldest].sent) oldest = i;
          end
          hit = oldest;
          r.evicted = 1'b1;
        end
        ack_table[hit].active = 1'b1;
        ack_table[hit].pkt = it.packet_id;
        ack_table[hit].node = it.node_id;
        ack_table[hit].sent = it.time_ms;
        ack_table[hit].pki = it.used_pki;
        r.slot_used = 3'(hit);
      end
      CMD_RESULT: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (hit < 0 && ack_table[i].active && ack_table[i].pkt == it.packet_id &&
              ack_table[i].node == it.node_id) hit = i;
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (hit < 0 && ack_table[i].active && ack_table[i].pkt == it.packet_id) hit = i;
        end
        if (hit >= 0) begin
          ack_table[hit].active = 1'b0;
          r.matched = 1'b1;
          r.slot_used = 3'(hit);
          if (it.error_reason == ERR_ACK) begin
            r.acked = 1'b1;
            r.hint_valid = 1'b1;
            r.no_pki_hint = !ack_table[hit].pki;
          end else if (it.error_reason == ERR_NO_CHANNEL) begin
            r.hint_valid = 1'b1;
            r.no_pki_hint = ack_table[hit].pki;
          end
        end
      end
      CMD_DROP: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (ack_table[i].active && ack_table[i].node == it.node_id) begin
            ack_table[i].active = 1'b0;
            cnt++;
          end
        end
        r.dropped_count = (cnt > int'(DROP_MAX)) ? DROP_MAX : CNT_W'(cnt);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int idle_pct();
    if (sent_cnt < 600) return 38;
    if (sent_cnt < 1200) return 71;
    return 0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expect_q.push_back(track_step(item_d));
      if (!start || !busy) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= idle_pct()) begin
          item_d <= stim_q.pop_front();
          start <= 1'b1;
          sent_cnt++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none got %p", $time, result);
        fail_cnt++;
      end else begin
        want = expect_q.pop_front();
        check_field("matched", 4'(want.matched), 4'(result.matched));
        check_field("acked", 4'(want.acked), 4'(result.acked));
        check_field("hint_valid", 4'(want.hint_valid), 4'(result.hint_valid));
        check_field("no_pki_hint", 4'(want.no_pki_hint), 4'(result.no_pki_hint));
        check_field("slot_used", 4'(want.slot_used), 4'(result.slot_used));
        check_field("evicted", 4'(want.evicted), 4'(result.evicted));
        check_field("dropped_count", want.dropped_count, result.dropped_count);
      end
    end
  end

  task automatic push_item(logic [1:0] cmd, logic [31:0] node, logic [31:0] pkt,
                           logic [7:0] err, logic pki, logic [31:0] t);
    item_t it;
    it.command = cmd;
    it.node_id = node;
    it.packet_id = pkt;
    it.error_reason = err;
    it.used_pki = pki;
    it.time_ms = t;
    stim_q.push_back(it);
  endtask

  task automatic wait_idle();
    while (stim_q.size() != 0 || start || expect_q.size() != 0) @(posedge clk);
  endtask

  // Mostly records and results on recently recorded packets, with some noise.
  task automatic gen_random(int n);
    int          made;
    int          pick;
    logic [1:0]  cmd;
    logic [31:0] node;
    logic [31:0] pkt;
    logic [7:0]  err;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 45) cmd = CMD_RECORD;
      else if (pick < 85) cmd = CMD_RESULT;
      else if (pick < 95) cmd = CMD_DROP;
      else cmd = CMD_UNUSED;

      node = ($urandom_range(9) == 0) ? $urandom : node_pool[$urandom_range(3)];
      if (cmd == CMD_RESULT && recent_pkts.size() != 0 && $urandom_range(99) < 75)
        pkt = recent_pkts[$urandom_range(recent_pkts.size() - 1)];
      else if ($urandom_range(1) == 0)
        pkt = 32'($urandom_range(15));
      else
        pkt = $urandom;

      pick = $urandom_range(99);
      if (pick < 40) err = ERR_ACK;
      else if (pick < 65) err = ERR_NO_CHANNEL;
      else err = 8'($urandom_range(255));

      pick = $urandom_range(99);
      if (pick < 15) clock_ms = $urandom;
      else if (pick >= 25) clock_ms = clock_ms + 32'($urandom_range(1, 50));

      if (cmd == CMD_RECORD) begin
        recent_pkts.push_back(pkt);
        if (recent_pkts.size() > 12) void'(recent_pkts.pop_front());
      end
      push_item(cmd, node, pkt, err, 1'($urandom_range(1)), clock_ms);
      if (cmd != CMD_UNUSED) made++;
    end
  endtask

  initial begin
    foreach (ack_table[i]) ack_table[i] = '0;
    foreach (node_pool[i]) node_pool[i] = $urandom;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty table: no match, unused command, empty drop
    push_item(CMD_RESULT, '1, '1, 8'hFF, 1'b1, '1);
    push_item(CMD_UNUSED, '1, '1, 8'hFF, 1'b1, '1);
    push_item(CMD_DROP, 32'h0, 32'h0, 8'h0, 1'b0, 32'h0);
    // fill all slots; ties, duplicate packet ids, time extremes
    push_item(CMD_RECORD, 32'h0, 32'h0, 8'h0, 1'b1, 32'hFFFF_FFFF);
    push_item(CMD_RECORD, '1, '1, 8'h0, 1'b0, 32'd100);
    push_item(CMD_RECORD, 32'hA5A5_A5A5, 32'h11, 8'h0, 1'b1, 32'd100);
    push_item(CMD_RECORD, 32'h5A5A_5A5A, 32'h11, 8'h0, 1'b0, 32'd200);
    push_item(CMD_RECORD, 32'hA5A5_A5A5, 32'h22, 8'h0, 1'b0, 32'd0);
    push_item(CMD_RECORD, 32'hA5A5_A5A5, 32'h33, 8'h0, 1'b1, 32'd300);
    push_item(CMD_RECORD, 32'h5A5A_5A5A, 32'h44, 8'h0, 1'b1, 32'd300);
    push_item(CMD_RECORD, 32'hA5A5_A5A5, 32'h55, 8'h0, 1'b0, 32'd400);
    // full table: evict the zero time, then the lowest index of a tie
    push_item(CMD_RECORD, 32'h1, 32'h66, 8'h0, 1'b0, 32'd1000);
    push_item(CMD_RECORD, 32'h2, 32'h77, 8'h0, 1'b1, 32'd1000);
    // exact match beats a lower packet-only match, then packet-only, other error
    push_item(CMD_RESULT, 32'h5A5A_5A5A, 32'h11, ERR_ACK, 1'b0, 32'h0);
    push_item(CMD_RESULT, 32'h1234_5678, 32'h11, ERR_NO_CHANNEL, 1'b0, 32'h0);
    push_item(CMD_RESULT, 32'h0, 32'h0, 8'hFF, 1'b1, '1);
    push_item(CMD_RESULT, 32'h5A5A_5A5A, 32'h44, ERR_ACK, 1'b0, 32'h0);
    push_item(CMD_RESULT, 32'h1, 32'h66, ERR_NO_CHANNEL, 1'b1, 32'h0);
    push_item(CMD_RESULT, 32'h2, 32'h77, 8'h01, 1'b0, 32'h0);
    push_item(CMD_DROP, 32'hA5A5_A5A5, '1, 8'hFF, 1'b1, '1);
    push_item(CMD_DROP, 32'hA5A5_A5A5, 32'h0, 8'h0, 1'b0, 32'h0);
    push_item(CMD_RECORD, 32'h3, 32'h88, 8'h0, 1'b1, 32'd2000);
    wait_idle();

    // random part in batches, fully drained between them
    for (int b = 0; b < RAND_ITEMS / BATCH; b++) begin
      gen_random(BATCH);
      wait_idle();
    end

    repeat (SLOTS + 4) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("** pending_ack_tracker: PASSED **");
    end else begin
      $display("** pending_ack_tracker: FAILED **");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("** pending_ack_tracker: FAILED **");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/pat_pkg.sv
hw/rtl/pat_cell.sv
hw/rtl/pending_ack_tracker.sv
test/testbench.sv
